[design/ppc_pkg.sv]
// Shared types, constants and the saturation helper of the particle plane collision unit.
package ppc_pkg;

  typedef logic signed [31:0] q16_t;

  // Width that holds every intermediate sum before clamping.
  localparam int unsigned SAT_W = 66;

  // Cycles from an accepted start to the matching done strobe.
  localparam int unsigned LATENCY = 8;

  localparam logic [16:0] FRIC_ONE = 17'd65536;

  // 0.0001 in Q0.32
  localparam logic signed [19:0] OFFSET_Q32 = 20'sd429497;

  typedef enum logic [2:0] {
    REG_POINT_X  = 3'd0,
    REG_POINT_Y  = 3'd1,
    REG_POINT_Z  = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5,
    REG_FRICTION = 3'd6,
    REG_INV_LEN  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_e;

  typedef struct packed {
    q16_t pos_x;
    q16_t pos_y;
    q16_t pos_z;
    q16_t prev_x;
    q16_t prev_y;
    q16_t prev_z;
  } item_t;

  typedef struct packed {
    q16_t new_x;
    q16_t new_y;
    q16_t new_z;
    logic collided;
  } result_t;

  typedef struct packed {
    q16_t        plane_point_x;
    q16_t        plane_point_y;
    q16_t        plane_point_z;
    q16_t        plane_normal_x;
    q16_t        plane_normal_y;
    q16_t        plane_normal_z;
    logic [16:0] friction_coeff;
    logic [31:0] inv_normal_len_sq;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    dir_e  dir;
    q16_t  dot;
    item_t item;
  } side_t;

  typedef struct packed {
    logic  valid;
    dir_e  dir;
    q16_t  isect_x;
    q16_t  isect_y;
    q16_t  isect_z;
    item_t item;
  } proj_t;

  // Clamp to the signed 32 bit range.
  function automatic q16_t sat32(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-32:0] hi;
    hi = v[SAT_W-1:31];
    if ((&hi) || (~|hi)) begin
      return v[31:0];
    end else if (v[SAT_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

endpackage

[design/ppc_regs.sv]
// APB configuration register file of the particle plane collision unit.
module ppc_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ppc_pkg::cfg_t       cfg_o
);

  ppc_pkg::cfg_t     cfg_q;
  ppc_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = ppc_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plane_point_x     <= '0;
      cfg_q.plane_point_y     <= '0;
      cfg_q.plane_point_z     <= '0;
      cfg_q.plane_normal_x    <= '0;
      cfg_q.plane_normal_y    <= 32'sd65536;
      cfg_q.plane_normal_z    <= '0;
      cfg_q.friction_coeff    <= '0;
      cfg_q.inv_normal_len_sq <= 32'd65536;
    end else if (wr_en) begin
      unique case (idx)
        ppc_pkg::REG_POINT_X:  cfg_q.plane_point_x     <= pwdata;
        ppc_pkg::REG_POINT_Y:  cfg_q.plane_point_y     <= pwdata;
        ppc_pkg::REG_POINT_Z:  cfg_q.plane_point_z     <= pwdata;
        ppc_pkg::REG_NORMAL_X: cfg_q.plane_normal_x    <= pwdata;
        ppc_pkg::REG_NORMAL_Y: cfg_q.plane_normal_y    <= pwdata;
        ppc_pkg::REG_NORMAL_Z: cfg_q.plane_normal_z    <= pwdata;
        ppc_pkg::REG_FRICTION: cfg_q.friction_coeff    <= pwdata[16:0];
        ppc_pkg::REG_INV_LEN:  cfg_q.inv_normal_len_sq <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ppc_pkg::REG_POINT_X:  prdata = cfg_q.plane_point_x;
      ppc_pkg::REG_POINT_Y:  prdata = cfg_q.plane_point_y;
      ppc_pkg::REG_POINT_Z:  prdata = cfg_q.plane_point_z;
      ppc_pkg::REG_NORMAL_X: prdata = cfg_q.plane_normal_x;
      ppc_pkg::REG_NORMAL_Y: prdata = cfg_q.plane_normal_y;
      ppc_pkg::REG_NORMAL_Z: prdata = cfg_q.plane_normal_z;
      ppc_pkg::REG_FRICTION: prdata = {15'd0, cfg_q.friction_coeff};
      ppc_pkg::REG_INV_LEN:  prdata = cfg_q.inv_normal_len_sq;
    endcase
  end

endmodule

[design/ppc_side.sv]
// Side test stages: exact plane dot products of both positions and crossing direction.
module ppc_side (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  ppc_pkg::item_t item_i,
  input  ppc_pkg::cfg_t  cfg_i,
  output ppc_pkg::side_t side_o
);

  logic signed [31:0] pt  [3];
  logic signed [31:0] nrm [3];
  logic signed [31:0] cur [3];
  logic signed [31:0] prv [3];

  logic signed [64:0] pc_d [3];
  logic signed [64:0] pp_d [3];
  logic signed [64:0] pc_q [3];
  logic signed [64:0] pp_q [3];
  logic               v1_q;
  ppc_pkg::item_t     item1_q;

  logic signed [ppc_pkg::SAT_W-1:0] sum_c;
  logic signed [ppc_pkg::SAT_W-1:0] sum_p;
  logic                             cur_pos, cur_neg, prv_pos, prv_neg;
  ppc_pkg::dir_e                    dir_d;
  ppc_pkg::side_t                   side_q;
  logic                             v2_q;

  assign pt[0]  = cfg_i.plane_point_x;
  assign pt[1]  = cfg_i.plane_point_y;
  assign pt[2]  = cfg_i.plane_point_z;
  assign nrm[0] = cfg_i.plane_normal_x;
  assign nrm[1] = cfg_i.plane_normal_y;
  assign nrm[2] = cfg_i.plane_normal_z;
  assign cur[0] = item_i.pos_x;
  assign cur[1] = item_i.pos_y;
  assign cur[2] = item_i.pos_z;
  assign prv[0] = item_i.prev_x;
  assign prv[1] = item_i.prev_y;
  assign prv[2] = item_i.prev_z;

  // Stage 1: per-axis (point - p) * normal, exact.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pc_d[k] = (65'(pt[k]) - 65'(cur[k])) * 65'(nrm[k]);
      pp_d[k] = (65'(pt[k]) - 65'(prv[k])) * 65'(nrm[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item1_q <= item_i;
    for (int k = 0; k < 3; k++) begin
      pc_q[k] <= pc_d[k];
      pp_q[k] <= pp_d[k];
    end
  end

  // Stage 2: sum the axes, take signs, classify the crossing.
  always_comb begin
    sum_c   = ppc_pkg::SAT_W'(pc_q[0]) + ppc_pkg::SAT_W'(pc_q[1]) + ppc_pkg::SAT_W'(pc_q[2]);
    sum_p   = ppc_pkg::SAT_W'(pp_q[0]) + ppc_pkg::SAT_W'(pp_q[1]) + ppc_pkg::SAT_W'(pp_q[2]);
    cur_neg = sum_c[ppc_pkg::SAT_W-1];
    cur_pos = !cur_neg && (|sum_c);
    prv_neg = sum_p[ppc_pkg::SAT_W-1];
    prv_pos = !prv_neg && (|sum_p);
    if (cur_pos && !prv_pos) begin
      dir_d = ppc_pkg::DIR_POS;
    end else if (cur_neg && !prv_neg) begin
      dir_d = ppc_pkg::DIR_NEG;
    end else begin
      dir_d = ppc_pkg::DIR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q.valid <= 1'b0;
    side_q.dir   <= dir_d;
    side_q.dot   <= ppc_pkg::sat32(sum_c >>> 16);
    side_q.item  <= item1_q;
  end

  always_comb begin
    side_o       = side_q;
    side_o.valid = v2_q;
  end

endmodule

[design/ppc_proj.sv]
// Projection stages: scale factor from the reciprocal and the plane intersection point.
module ppc_proj (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppc_pkg::side_t side_i,
  input  ppc_pkg::cfg_t  cfg_i,
  output ppc_pkg::proj_t proj_o
);

  logic signed [31:0] nrm [3];
  logic signed [31:0] pos [3];

  // Stage 3
  logic signed [64:0] tprod_d, tprod_q;
  logic               v3_q;
  ppc_pkg::dir_e      dir3_q;
  ppc_pkg::item_t     item3_q;

  // Stage 4
  ppc_pkg::q16_t      t;
  logic signed [63:0] tn_d [3];
  logic signed [63:0] tn_q [3];
  logic               v4_q;
  ppc_pkg::dir_e      dir4_q;
  ppc_pkg::item_t     item4_q;

  // Stage 5
  ppc_pkg::q16_t      is_d [3];
  ppc_pkg::q16_t      is_q [3];
  logic               v5_q;
  ppc_pkg::dir_e      dir5_q;
  ppc_pkg::item_t     item5_q;

  assign nrm[0] = cfg_i.plane_normal_x;
  assign nrm[1] = cfg_i.plane_normal_y;
  assign nrm[2] = cfg_i.plane_normal_z;
  assign pos[0] = item4_q.pos_x;
  assign pos[1] = item4_q.pos_y;
  assign pos[2] = item4_q.pos_z;

  assign tprod_d = 65'(side_i.dot) * $signed({33'd0, cfg_i.inv_normal_len_sq});

  always_comb begin
    t = ppc_pkg::sat32(ppc_pkg::SAT_W'(tprod_q >>> 16));
    for (int k = 0; k < 3; k++) begin
      tn_d[k] = 64'(t) * 64'(nrm[k]);
      is_d[k] = ppc_pkg::sat32(ppc_pkg::SAT_W'(pos[k]) + ppc_pkg::SAT_W'(tn_q[k] >>> 16));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= side_i.valid;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tprod_q <= tprod_d;
    dir3_q  <= side_i.dir;
    item3_q <= side_i.item;
    dir4_q  <= dir3_q;
    item4_q <= item3_q;
    dir5_q  <= dir4_q;
    item5_q <= item4_q;
    for (int k = 0; k < 3; k++) begin
      tn_q[k] <= tn_d[k];
      is_q[k] <= is_d[k];
    end
  end

  always_comb begin
    proj_o.valid   = v5_q;
    proj_o.dir     = dir5_q;
    proj_o.isect_x = is_q[0];
    proj_o.isect_y = is_q[1];
    proj_o.isect_z = is_q[2];
    proj_o.item    = item5_q;
  end

endmodule

[design/ppc_resp.sv]
// Response stages: surface offset, friction scaling and the result register.
module ppc_resp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ppc_pkg::proj_t   proj_i,
  input  ppc_pkg::cfg_t    cfg_i,
  output logic             done_o,
  output ppc_pkg::result_t result_o
);

  logic signed [31:0] nrm  [3];
  logic signed [31:0] isec [3];
  logic signed [31:0] prv6 [3];
  logic signed [31:0] prv8 [3];
  logic signed [31:0] pos8 [3];

  // Values that follow from configuration alone.
  logic signed [51:0] ofs_prod [3];
  logic signed [19:0] ofs_q    [3];
  logic [16:0]        scale_d, scale_q;

  // Stage 6
  ppc_pkg::q16_t      c_d [3];
  ppc_pkg::q16_t      c_q [3];
  logic               v6_q;
  ppc_pkg::dir_e      dir6_q;
  ppc_pkg::item_t     item6_q;

  // Stage 7
  logic signed [49:0] cs_d [3];
  logic signed [49:0] cs_q [3];
  logic               v7_q;
  ppc_pkg::dir_e      dir7_q;
  ppc_pkg::item_t     item7_q;

  // Stage 8
  ppc_pkg::q16_t      nw [3];
  ppc_pkg::result_t   res_d, res_q;
  logic               done_q;

  assign nrm[0]  = cfg_i.plane_normal_x;
  assign nrm[1]  = cfg_i.plane_normal_y;
  assign nrm[2]  = cfg_i.plane_normal_z;
  assign isec[0] = proj_i.isect_x;
  assign isec[1] = proj_i.isect_y;
  assign isec[2] = proj_i.isect_z;
  assign prv6[0] = proj_i.item.prev_x;
  assign prv6[1] = proj_i.item.prev_y;
  assign prv6[2] = proj_i.item.prev_z;
  assign prv8[0] = item7_q.prev_x;
  assign prv8[1] = item7_q.prev_y;
  assign prv8[2] = item7_q.prev_z;
  assign pos8[0] = item7_q.pos_x;
  assign pos8[1] = item7_q.pos_y;
  assign pos8[2] = item7_q.pos_z;

  // Clamp friction to 1.0 so the scale never goes negative.
  assign scale_d = (cfg_i.friction_coeff >= ppc_pkg::FRIC_ONE) ? 17'd0
                                                              : ppc_pkg::FRIC_ONE - cfg_i.friction_coeff;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ofs_prod[k] = 52'(nrm[k]) * 52'(ppc_pkg::OFFSET_Q32);
      if (proj_i.dir == ppc_pkg::DIR_POS) begin
        c_d[k] = ppc_pkg::sat32(ppc_pkg::SAT_W'(isec[k]) - ppc_pkg::SAT_W'(prv6[k])
                                + ppc_pkg::SAT_W'(ofs_q[k]));
      end else begin
        c_d[k] = ppc_pkg::sat32(ppc_pkg::SAT_W'(isec[k]) - ppc_pkg::SAT_W'(prv6[k])
                                - ppc_pkg::SAT_W'(ofs_q[k]));
      end
      cs_d[k] = 50'(c_q[k]) * $signed({33'd0, scale_q});
      nw[k]   = ppc_pkg::sat32(ppc_pkg::SAT_W'(prv8[k]) + ppc_pkg::SAT_W'(cs_q[k] >>> 16));
    end
  end

  // Pass the position through untouched when nothing crossed.
  always_comb begin
    if (dir7_q != ppc_pkg::DIR_NONE) begin
      res_d.new_x    = nw[0];
      res_d.new_y    = nw[1];
      res_d.new_z    = nw[2];
      res_d.collided = 1'b1;
    end else begin
      res_d.new_x    = pos8[0];
      res_d.new_y    = pos8[1];
      res_d.new_z    = pos8[2];
      res_d.collided = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v6_q   <= proj_i.valid;
      v7_q   <= v6_q;
      done_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q <= scale_d;
    dir6_q  <= proj_i.dir;
    item6_q <= proj_i.item;
    dir7_q  <= dir6_q;
    item7_q <= item6_q;
    res_q   <= res_d;
    for (int k = 0; k < 3; k++) begin
      ofs_q[k] <= ofs_prod[k][51:32];
      c_q[k]   <= c_d[k];
      cs_q[k]  <= cs_d[k];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[design/particle_plane_collision_unit.sv]
// Top level of the particle plane collision unit.
//
// Usage:
//  - Load the plane point, normal, friction and 1/(n.n) through the APB port
//    (register i at byte address 4*i) while no transaction is in flight.
//  - Present a particle's current and previous position on item_i with
//    start high; the transaction is taken at that edge. busy never rises,
//    so a new particle may be issued on every clock.
//  - Each transaction yields exactly one result: result_o is valid for the one
//    cycle that done_o is high, once the transaction has left the last stage.
//    Capture it then; the receiver has no way to hold it off.
//  - Throughput is one particle per clock. Latency is set by the eight
//    register stages of the datapath: two for the exact side tests, three for
//    the projection (reciprocal multiply, normal multiply, add), three for
//    the response (offset add, friction multiply, final add and output).
//  - Reset clears every stage valid bit so no done strobe appears until new
//    work enters, and returns the registers to a +Y normal through the
//    origin with no friction and 1/(n.n) = 1.0.
//  - Results leave in issue order; nothing is dropped or repeated.
module particle_plane_collision_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  // APB configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // command channel
  input  logic             start,
  input  ppc_pkg::item_t   item_i,
  output logic             busy,
  // result channel
  output logic             done_o,
  output ppc_pkg::result_t result_o
);

  ppc_pkg::cfg_t  cfg;
  ppc_pkg::side_t side;
  ppc_pkg::proj_t proj;
  logic           accept;

  // The pipeline never stalls, so hold busy low and take every start.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  ppc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stages 1-2: signed sides of both positions, crossing direction, clamped dot.
  ppc_side u_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item_i),
    .cfg_i   (cfg),
    .side_o  (side)
  );

  // Stages 3-5: projection factor and intersection with the plane.
  ppc_proj u_proj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side),
    .cfg_i  (cfg),
    .proj_o (proj)
  );

  // Stages 6-8: push off the surface, apply friction, register the result.
  ppc_resp u_resp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .proj_i   (proj),
    .cfg_i    (cfg),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

[design/ppc_checker.sv]
// Port-level checker for the particle plane collision unit and its bind.
module ppc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input ppc_pkg::item_t   item_i,
  input logic             done_o,
  input ppc_pkg::result_t result_o
);

  // Every accepted transaction returns its result after the fixed latency.
  a_start_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(ppc_pkg::LATENCY) done_o)
    else $error("accepted transaction produced no done strobe");

  // No done strobe without a transaction accepted the latency earlier.
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && rst_ni, ppc_pkg::LATENCY))
    else $error("done strobe without a matching transaction");

  // Without a collision the position comes back unchanged.
  a_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.collided) |->
      (result_o.new_x == $past(item_i.pos_x, ppc_pkg::LATENCY)) &&
      (result_o.new_y == $past(item_i.pos_y, ppc_pkg::LATENCY)) &&
      (result_o.new_z == $past(item_i.pos_z, ppc_pkg::LATENCY)))
    else $error("non-colliding result differs from its input position");

endmodule

bind particle_plane_collision_unit ppc_checker u_ppc_checker (.*);

[sim/tb_particle_plane_collision_unit.sv]
// Self-checking testbench for the particle plane collision unit.
module tb_particle_plane_collision_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef ppc_pkg::q16_t    q16_t;
  typedef ppc_pkg::item_t   item_t;
  typedef ppc_pkg::result_t result_t;
  typedef ppc_pkg::cfg_t    cfg_t;

  // Intermediate width: every product and sum of the datapath fits without loss.
  typedef logic signed [127:0] wide_t;

  localparam q16_t  Q_ONE = 32'sh0001_0000;
  localparam q16_t  Q_TOP = 32'sh7fff_ffff;
  localparam q16_t  Q_BOT = 32'sh8000_0000;
  localparam wide_t WIDE_TOP = 128'sd2147483647;
  localparam wide_t WIDE_BOT = -128'sd2147483648;
  localparam wide_t WIDE_OFFSET = ppc_pkg::OFFSET_Q32;
  localparam wide_t WIDE_FRIC_ONE = ppc_pkg::FRIC_ONE;

  // Cycles without any accepted transaction or done strobe before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES = 9;
  localparam int unsigned ITEMS_PER_PHASE = 134;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  item_t       item_i = '0;
  logic        busy;
  logic        done_o;
  result_t     result_o;

  // Shadow copy of the plane registers, updated as each APB write lands.
  cfg_t        plane_cfg;
  // Particles waiting to be issued, and corrected positions waiting to come back.
  item_t       particle_queue[$];
  result_t     predicted_results[$];
  result_t     oldest_expected;
  int unsigned sender_idle_pct = 6;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  particle_plane_collision_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic q16_t clamp_q16(input wide_t v);
    if (v > WIDE_TOP) begin
      return Q_TOP;
    end else if (v < WIDE_BOT) begin
      return Q_BOT;
    end
    return v[31:0];
  endfunction

  // Exact signed distance (point - p) . normal, scaled by 2^32.
  function automatic wide_t plane_side(input cfg_t cfg, input q16_t x, input q16_t y,
                                       input q16_t z);
    wide_t px, py, pz, nx, ny, nz, wx, wy, wz;
    px = $signed(cfg.plane_point_x);
    py = $signed(cfg.plane_point_y);
    pz = $signed(cfg.plane_point_z);
    nx = $signed(cfg.plane_normal_x);
    ny = $signed(cfg.plane_normal_y);
    nz = $signed(cfg.plane_normal_z);
    wx = x;
    wy = y;
    wz = z;
    return (px - wx) * nx + (py - wy) * ny + (pz - wz) * nz;
  endfunction

  // Project one coordinate onto the plane, nudge it off the surface toward the
  // start side, then shrink the move from the previous position by friction.
  function automatic q16_t respond_axis(input q16_t pos, input q16_t prev, input q16_t n,
                                        input q16_t t, input ppc_pkg::dir_e dir,
                                        input wide_t scale);
    wide_t wp, wq, wn, wt, wi, wo, wc;
    wp = pos;
    wq = prev;
    wn = n;
    wt = t;
    wi = clamp_q16(wp + ((wt * wn) >>> 16));
    wo = (wn * WIDE_OFFSET) >>> 32;
    wc = clamp_q16((dir == ppc_pkg::DIR_POS) ? (wi - wq + wo) : (wi - wq - wo));
    return clamp_q16(wq + ((wc * scale) >>> 16));
  endfunction

  function automatic result_t predict_collision(input item_t it, input cfg_t cfg);
    wide_t         side_cur, side_prev, dot_q, inv, fric, scale;
    q16_t          t;
    ppc_pkg::dir_e dir;
    result_t       r;
    side_cur  = plane_side(cfg, it.pos_x, it.pos_y, it.pos_z);
    side_prev = plane_side(cfg, it.prev_x, it.prev_y, it.prev_z);
    if (side_cur > 0 && side_prev <= 0) begin
      dir = ppc_pkg::DIR_POS;
    end else if (side_cur < 0 && side_prev >= 0) begin
      dir = ppc_pkg::DIR_NEG;
    end else begin
      dir = ppc_pkg::DIR_NONE;
    end
    r.new_x    = it.pos_x;
    r.new_y    = it.pos_y;
    r.new_z    = it.pos_z;
    r.collided = 1'b0;
    if (dir != ppc_pkg::DIR_NONE) begin
      fric = cfg.friction_coeff;
      if (fric > WIDE_FRIC_ONE) begin
        fric = WIDE_FRIC_ONE;
      end
      scale = WIDE_FRIC_ONE - fric;
      dot_q = clamp_q16(side_cur >>> 16);
      inv   = cfg.inv_normal_len_sq;
      t     = clamp_q16((dot_q * inv) >>> 16);
      r.new_x = respond_axis(it.pos_x, it.prev_x, cfg.plane_normal_x, t, dir, scale);
      r.new_y = respond_axis(it.pos_y, it.prev_y, cfg.plane_normal_y, t, dir, scale);
      r.new_z = respond_axis(it.pos_z, it.prev_z, cfg.plane_normal_z, t, dir, scale);
      r.collided = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic q16_t extreme_coord();
    case ($urandom_range(0, 3))
      0: return Q_BOT;
      1: return Q_TOP;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Coordinate within +-16.0 of the plane point; sometimes exactly on it.
  function automatic q16_t near_coord(input q16_t center);
    if ($urandom_range(0, 9) == 0) begin
      return center;
    end
    return center + q16_t'(int'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  function automatic item_t make_particle(input cfg_t cfg);
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      // Well-formed: both positions close to the plane, so about half cross it.
      it.pos_x  = near_coord(cfg.plane_point_x);
      it.pos_y  = near_coord(cfg.plane_point_y);
      it.pos_z  = near_coord(cfg.plane_point_z);
      it.prev_x = near_coord(cfg.plane_point_x);
      it.prev_y = near_coord(cfg.plane_point_y);
      it.prev_z = near_coord(cfg.plane_point_z);
      // Land exactly on the plane now and then to hit the zero-side cases.
      case ($urandom_range(0, 19))
        0: begin
          it.pos_x = cfg.plane_point_x;
          it.pos_y = cfg.plane_point_y;
          it.pos_z = cfg.plane_point_z;
        end
        1: begin
          it.prev_x = cfg.plane_point_x;
          it.prev_y = cfg.plane_point_y;
          it.prev_z = cfg.plane_point_z;
        end
        default: ;
      endcase
    end else if (pick < 85) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      it.pos_x  = extreme_coord();
      it.pos_y  = extreme_coord();
      it.pos_z  = extreme_coord();
      it.prev_x = extreme_coord();
      it.prev_y = extreme_coord();
      it.prev_z = extreme_coord();
    end
    return it;
  endfunction

  task automatic push_particle(input q16_t px, input q16_t py, input q16_t pz,
                               input q16_t qx, input q16_t qy, input q16_t qz);
    item_t it;
    it = {px, py, pz, qx, qy, qz};
    particle_queue.push_back(it);
  endtask

  // One APB write: setup cycle, then access cycle; mirror it in the shadow copy.
  task automatic apb_write(input ppc_pkg::reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ppc_pkg::REG_POINT_X:  plane_cfg.plane_point_x     = value;
      ppc_pkg::REG_POINT_Y:  plane_cfg.plane_point_y     = value;
      ppc_pkg::REG_POINT_Z:  plane_cfg.plane_point_z     = value;
      ppc_pkg::REG_NORMAL_X: plane_cfg.plane_normal_x    = value;
      ppc_pkg::REG_NORMAL_Y: plane_cfg.plane_normal_y    = value;
      ppc_pkg::REG_NORMAL_Z: plane_cfg.plane_normal_z    = value;
      ppc_pkg::REG_FRICTION: plane_cfg.friction_coeff    = value[16:0];
      ppc_pkg::REG_INV_LEN:  plane_cfg.inv_normal_len_sq = value;
      default: ;
    endcase
  endtask

  // Program a fresh plane. The phase number picks the normal's flavor (axis
  // aligned, moderate, extreme, zero) and the friction setting, so the
  // extremes of every register come up over the run.
  task automatic program_plane(input int unsigned phase);
    q16_t        pt[3];
    q16_t        nrm[3];
    logic [31:0] fric;
    logic [31:0] inv;
    wide_t       nn, quot;
    int unsigned kind;
    kind = phase % 4;
    for (int k = 0; k < 3; k++) begin
      pt[k]  = (kind == 2) ? q16_t'($urandom) : q16_t'(int'($urandom_range(0, 4194304)) - 2097152);
      nrm[k] = '0;
    end
    case (kind)
      0: begin
        nrm[$urandom_range(0, 2)] = ($urandom_range(0, 1) ? Q_ONE : -Q_ONE) *
                                    q16_t'($urandom_range(1, 4));
      end
      1: begin
        for (int k = 0; k < 3; k++) begin
          nrm[k] = int'($urandom_range(0, 524288)) - 262144;
        end
      end
      2: begin
        for (int k = 0; k < 3; k++) begin
          nrm[k] = extreme_coord();
        end
      end
      default: ;
    endcase
    nn = 0;
    for (int k = 0; k < 3; k++) begin
      nn = nn + wide_t'(nrm[k]) * wide_t'(nrm[k]);
    end
    if (kind < 2) begin
      // Consistent reciprocal of n.n in Q16.16, clamped to the register width.
      if (nn == 0) begin
        inv = '1;
      end else begin
        quot = (wide_t'(1) <<< 48) / nn;
        inv  = (quot > wide_t'(32'hffff_ffff)) ? 32'hffff_ffff : quot[31:0];
      end
    end else begin
      case ($urandom_range(0, 2))
        0: inv = '0;
        1: inv = '1;
        default: inv = $urandom;
      endcase
    end
    case (phase % 5)
      0: fric = 32'd0;
      1: fric = 32'd65536;
      2: fric = $urandom;
      3: fric = $urandom_range(0, 65536);
      default: fric = 32'h0001_ffff;
    endcase
    apb_write(ppc_pkg::REG_POINT_X, pt[0]);
    apb_write(ppc_pkg::REG_POINT_Y, pt[1]);
    apb_write(ppc_pkg::REG_POINT_Z, pt[2]);
    apb_write(ppc_pkg::REG_NORMAL_X, nrm[0]);
    apb_write(ppc_pkg::REG_NORMAL_Y, nrm[1]);
    apb_write(ppc_pkg::REG_NORMAL_Z, nrm[2]);
    apb_write(ppc_pkg::REG_FRICTION, fric);
    apb_write(ppc_pkg::REG_INV_LEN, inv);
  endtask

  // Hold until every issued particle has come back, then let the pipeline
  // run dry so late strobes get caught.
  task automatic settle();
    while (particle_queue.size() != 0 || start || predicted_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (ppc_pkg::LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: issue queued particles, idling at random; record each accepted
  // transaction's expected result at the edge that takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted_results.push_back(predict_collision(item_i, plane_cfg));
      end
      // Hold the current particle while the block reports busy.
      if (!(start && busy)) begin
        if (particle_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          start  <= 1'b1;
          item_i <= particle_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done strobe is a transaction; match it to the oldest
  // expectation field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (predicted_results.size() == 0) begin
        flag_mismatch("result with nothing pending", result_o.new_x, '0);
      end else begin
        oldest_expected = predicted_results.pop_front();
        if (result_o.new_x !== oldest_expected.new_x) begin
          flag_mismatch("new_x", result_o.new_x, oldest_expected.new_x);
        end
        if (result_o.new_y !== oldest_expected.new_y) begin
          flag_mismatch("new_y", result_o.new_y, oldest_expected.new_y);
        end
        if (result_o.new_z !== oldest_expected.new_z) begin
          flag_mismatch("new_z", result_o.new_z, oldest_expected.new_z);
        end
        if (result_o.collided !== oldest_expected.collided) begin
          flag_mismatch("collided", {31'b0, result_o.collided},
                        {31'b0, oldest_expected.collided});
        end
      end
    end
  end

  // Watchdog: drop the run when neither side moves a transaction for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Reset values: +Y unit normal through the origin, no friction, 1/(n.n) = 1.0.
    plane_cfg = '0;
    plane_cfg.plane_normal_y    = Q_ONE;
    plane_cfg.inv_normal_len_sq = 32'h0001_0000;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed particles against the reset plane.
    sender_idle_pct = 6;
    push_particle(0, Q_ONE, 0, 0, -Q_ONE, 0);             // up through the plane
    push_particle(0, -Q_ONE, 0, 0, Q_ONE, 0);             // down through the plane
    push_particle(5, 0, 7, 0, Q_ONE, 0);                  // ends on the plane
    push_particle(0, Q_ONE, 0, 3, 0, 4);                  // starts on the plane, leaves up
    push_particle(0, -Q_ONE, 0, 0, 0, 0);                 // starts on the plane, leaves down
    push_particle(0, Q_ONE, 0, 0, 2 * Q_ONE, 0);          // stays above
    push_particle(0, -Q_ONE, 0, 0, -2 * Q_ONE, 0);        // stays below
    push_particle(0, 0, 0, 0, 0, 0);                      // everything on the plane
    push_particle(Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT);
    push_particle(Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP);
    push_particle(Q_TOP, Q_TOP, Q_TOP, Q_BOT, Q_BOT, Q_BOT);
    push_particle(Q_BOT, Q_BOT, Q_BOT, Q_TOP, Q_TOP, Q_TOP);
    push_particle(Q_TOP, -1, Q_BOT, Q_BOT, 1, Q_TOP);     // one-LSB crossing, wild x and z
    push_particle(0, 1, 0, 0, -1, 0);
    push_particle(3 * Q_ONE, -Q_ONE / 2, -Q_ONE, -Q_ONE, 2 * Q_ONE, Q_ONE);
    push_particle(Q_ONE, Q_BOT, -Q_ONE, -Q_ONE, Q_TOP, Q_ONE);
    push_particle(Q_ONE, Q_TOP, -Q_ONE, -Q_ONE, Q_BOT, Q_ONE);
    settle();

    // Random phases: reprogram the plane while idle, then stream particles.
    for (int unsigned phase = 1; phase <= RANDOM_PHASES; phase++) begin
      if (phase <= 3) begin
        sender_idle_pct = 6;
      end else if (phase <= 6) begin
        sender_idle_pct = 62;
      end else begin
        sender_idle_pct = 0;
      end
      program_plane(phase);
      @(negedge clk_i);
      for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
        particle_queue.push_back(make_particle(plane_cfg));
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
